FILE: rtl/tbsd_pkg.sv
`default_nettype none

package tbsd_pkg;

  // Grid defaults, in tile cells
  localparam int DEF_GRID_COLS = 160;
  localparam int DEF_GRID_ROWS = 100;

  // Stream codes
  localparam logic [7:0] BYTE_END      = 8'hFF;
  localparam int         HEAD_VERT_BIT = 7;
  localparam int         HEAD_HORZ_BIT = 6;
  localparam int         OFFSET_W      = 14;

  // Tile length in bytes
  localparam logic [2:0] TILE_LEN_SHORT = 3'd3;
  localparam logic [2:0] TILE_LEN_LONG  = 3'd6;

  // Command queue depth (power of two)
  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_PAINT = 2'd0,
    CMD_DROP  = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_FBYTE = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_DROP = 2'd1,
    KIND_DONE = 2'd2
  } res_kind_t;

  typedef struct packed {
    cmd_op_t         op;
    logic [7:0]      xs;
    logic [7:0]      ys;
    logic [7:0]      xe;
    logic [7:0]      ye;
    logic            four;
    logic            tile_done;
    logic [5:0][7:0] pat;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  x_start;
    logic [6:0]  y_start;
    logic [7:0]  x_end;
    logic [6:0]  y_end;
    logic        four_rows;
    logic [15:0] blue_rows;
    logic [15:0] red_rows;
    logic [15:0] green_rows;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tbsd_if.sv
`default_nettype none

interface tbsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tbsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  x_start;
  logic [6:0]  y_start;
  logic [7:0]  x_end;
  logic [6:0]  y_end;
  logic        four_rows;
  logic [15:0] blue_rows;
  logic [15:0] red_rows;
  logic [15:0] green_rows;

  modport source (
    output valid, output kind, output x_start, output y_start, output x_end,
    output y_end, output four_rows, output blue_rows, output red_rows,
    output green_rows, input ready
  );
  modport sink (
    input valid, input kind, input x_start, input y_start, input x_end,
    input y_end, input four_rows, input blue_rows, input red_rows,
    input green_rows, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/tbsd_cmd_fifo.sv
`default_nettype none

module tbsd_cmd_fifo
  import tbsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  cmd_t        push_cmd,
  input  wire logic   pop,
  output cmd_t        head,
  output qstat_t      stat
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tbsd_front.sv
`default_nettype none

module tbsd_front
  import tbsd_pkg::*;
#(
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int GRID_ROWS = DEF_GRID_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_ready,
  input  wire logic       init_done,
  input  qstat_t          q_stat,
  output logic            push,
  output cmd_t            push_cmd
);

  // Offset split: q = (off * RECIP) >> OFFSET_W is exact or one low
  localparam int         RECIP    = (1 << OFFSET_W) / GRID_COLS;
  localparam int         PROD_W   = 2 * OFFSET_W;
  localparam int         QC_W     = OFFSET_W + 8;
  localparam logic [8:0] COLS9    = 9'(GRID_COLS);
  localparam logic [13:0] COLS14  = 14'(GRID_COLS);
  localparam logic [13:0] ROWS14  = 14'(GRID_ROWS);

  typedef enum logic [12:0] {
    PH_MODE  = 13'b0_0000_0000_0001,
    PH_TILE  = 13'b0_0000_0000_0010,
    PH_RHEAD = 13'b0_0000_0000_0100,
    PH_RLOW  = 13'b0_0000_0000_1000,
    PH_DIV1  = 13'b0_0000_0001_0000,
    PH_DIV2  = 13'b0_0000_0010_0000,
    PH_DIV3  = 13'b0_0000_0100_0000,
    PH_VERT  = 13'b0_0000_1000_0000,
    PH_HORZ  = 13'b0_0001_0000_0000,
    PH_BOTHX = 13'b0_0010_0000_0000,
    PH_BOTHY = 13'b0_0100_0000_0000,
    PH_CELLX = 13'b0_1000_0000_0000,
    PH_CELLY = 13'b1_0000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CLS_EMPTY = 2'd0,
    CLS_DROP  = 2'd1,
    CLS_PAINT = 2'd2
  } rect_cls_t;

  phase_t                 phase_r, phase_nxt;
  logic                   fill_r, fill_nxt;
  logic                   lm_nz_r, lm_nz_nxt;
  logic                   lm_gt1_r, lm_gt1_nxt;
  logic [2:0]             tcnt_r, tcnt_nxt;
  logic [5:0][7:0]        pat_r, pat_nxt;
  logic [7:0]             head_r, head_nxt;
  logic [OFFSET_W-1:0]    off_r, off_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [OFFSET_W-1:0]    q_r, q_nxt;
  logic [8:0]             rem_r, rem_nxt;
  logic [7:0]             first_r, first_nxt;

  logic                   acc;
  logic                   busy_div;
  logic [2:0]             t_need, t_k, t_k1;
  logic [5:0][7:0]        t_pat;
  logic                   t_done;
  logic [OFFSET_W-1:0]    q0;
  logic [QC_W-1:0]        diff;
  logic                   rect_go;
  logic [7:0]             r_xs, r_xe;
  logic [13:0]            r_ys, r_ye;
  rect_cls_t              cls;

  function automatic rect_cls_t classify(input logic [7:0] xs, input logic [13:0] ys,
                                         input logic [7:0] xe, input logic [13:0] ye);
    rect_cls_t c;
    if (xe < xs || ye < ys) begin
      c = CLS_EMPTY;
    end else if (14'(xs) >= COLS14 || 14'(xe) >= COLS14 || ys >= ROWS14 || ye >= ROWS14) begin
      c = CLS_DROP;
    end else begin
      c = CLS_PAINT;
    end
    return c;
  endfunction

  assign busy_div = (phase_r == PH_DIV1) || (phase_r == PH_DIV2) || (phase_r == PH_DIV3);
  assign in_ready = init_done && !q_stat.full && !busy_div;
  assign acc      = in_valid && in_ready;

  // Tile byte placement: a byte lands in slot k and, for the first plane
  // bytes, also in slot k+3 so short tiles repeat rows 0 and 1.
  always_comb begin
    t_need = lm_gt1_r ? TILE_LEN_LONG : TILE_LEN_SHORT;
    t_k    = (tcnt_r >= t_need) ? 3'd0 : tcnt_r;
    t_pat  = pat_r;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) == t_k || (t_k < TILE_LEN_SHORT && 3'(i) == t_k + TILE_LEN_SHORT)) begin
        t_pat[i] = in_byte;
      end
    end
    t_k1   = t_k + 3'd1;
    t_done = (t_k1 >= t_need);
  end

  assign q0   = prod_r[PROD_W-1:OFFSET_W];
  assign diff = QC_W'(off_r) - QC_W'(q0) * QC_W'(GRID_COLS);

  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    lm_nz_nxt  = lm_nz_r;
    lm_gt1_nxt = lm_gt1_r;
    tcnt_nxt   = tcnt_r;
    pat_nxt    = pat_r;
    head_nxt   = head_r;
    off_nxt    = off_r;
    prod_nxt   = prod_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    push       = 1'b0;
    push_cmd   = '0;
    rect_go    = 1'b0;
    r_xs       = rem_r[7:0];
    r_ys       = q_r;
    r_xe       = rem_r[7:0];
    r_ye       = q_r;

    if (fill_r) begin
      // After the closing end byte every transfer goes to the back as is
      if (acc) begin
        pat_nxt            = t_pat;
        tcnt_nxt           = t_done ? 3'd0 : t_k1;
        push               = 1'b1;
        push_cmd.op        = CMD_FBYTE;
        push_cmd.four      = lm_nz_r;
        push_cmd.tile_done = t_done;
        push_cmd.pat       = t_pat;
      end
    end else begin
      case (phase_r)
        PH_MODE: begin
          if (acc) begin
            tcnt_nxt = 3'd0;
            if (in_byte == BYTE_END) begin
              if (lm_nz_r) begin
                lm_gt1_nxt = 1'b1;
              end
              fill_nxt    = 1'b1;
              push        = 1'b1;
              push_cmd.op = CMD_FINAL;
            end else begin
              lm_nz_nxt  = (in_byte != 8'd0);
              lm_gt1_nxt = (in_byte > 8'd1);
              phase_nxt  = PH_TILE;
            end
          end
        end
        PH_TILE: begin
          if (acc) begin
            pat_nxt  = t_pat;
            tcnt_nxt = t_done ? 3'd0 : t_k1;
            if (t_done) begin
              phase_nxt = PH_RHEAD;
            end
          end
        end
        PH_RHEAD: begin
          if (acc) begin
            if (in_byte == BYTE_END) begin
              phase_nxt = PH_CELLX;
            end else begin
              head_nxt  = in_byte;
              phase_nxt = PH_RLOW;
            end
          end
        end
        PH_RLOW: begin
          if (acc) begin
            off_nxt   = {head_r[OFFSET_W-9:0], in_byte};
            phase_nxt = PH_DIV1;
          end
        end
        PH_DIV1: begin
          prod_nxt  = PROD_W'(off_r) * PROD_W'(RECIP);
          phase_nxt = PH_DIV2;
        end
        PH_DIV2: begin
          q_nxt     = q0;
          rem_nxt   = diff[8:0];
          phase_nxt = PH_DIV3;
        end
        PH_DIV3: begin
          if (rem_r >= COLS9) begin
            rem_nxt = rem_r - COLS9;
            q_nxt   = q_r + 1'b1;
          end
          if (head_r[HEAD_VERT_BIT]) begin
            phase_nxt = PH_VERT;
          end else if (head_r[HEAD_HORZ_BIT]) begin
            phase_nxt = PH_HORZ;
          end else begin
            phase_nxt = PH_BOTHX;
          end
        end
        PH_VERT: begin
          r_ye    = 14'(in_byte);
          rect_go = acc;
          if (acc) begin
            phase_nxt = PH_RHEAD;
          end
        end
        PH_HORZ: begin
          r_xe    = in_byte;
          rect_go = acc;
          if (acc) begin
            phase_nxt = PH_RHEAD;
          end
        end
        PH_BOTHX: begin
          if (acc) begin
            first_nxt = in_byte;
            phase_nxt = PH_BOTHY;
          end
        end
        PH_BOTHY: begin
          r_xe    = first_r;
          r_ye    = 14'(in_byte);
          rect_go = acc;
          if (acc) begin
            phase_nxt = PH_RHEAD;
          end
        end
        PH_CELLX: begin
          if (acc) begin
            if (in_byte == BYTE_END) begin
              phase_nxt = PH_MODE;
            end else begin
              first_nxt = in_byte;
              phase_nxt = PH_CELLY;
            end
          end
        end
        PH_CELLY: begin
          r_xs    = first_r;
          r_xe    = first_r;
          r_ys    = 14'(in_byte);
          r_ye    = 14'(in_byte);
          rect_go = acc;
          if (acc) begin
            phase_nxt = PH_CELLX;
          end
        end
        default: begin
          phase_nxt = PH_MODE;
        end
      endcase
    end

    // Drop empty rectangles here; everything else goes down the queue
    cls = classify(r_xs, r_ys, r_xe, r_ye);
    if (rect_go && cls != CLS_EMPTY) begin
      push          = 1'b1;
      push_cmd.op   = (cls == CLS_DROP) ? CMD_DROP : CMD_PAINT;
      push_cmd.xs   = r_xs;
      push_cmd.ys   = r_ys[7:0];
      push_cmd.xe   = r_xe;
      push_cmd.ye   = r_ye[7:0];
      push_cmd.four = lm_nz_r;
      push_cmd.pat  = pat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MODE;
      fill_r   <= 1'b0;
      lm_nz_r  <= 1'b0;
      lm_gt1_r <= 1'b0;
      tcnt_r   <= 3'd0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      lm_nz_r  <= lm_nz_nxt;
      lm_gt1_r <= lm_gt1_nxt;
      tcnt_r   <= tcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r   <= pat_nxt;
    head_r  <= head_nxt;
    off_r   <= off_nxt;
    prod_r  <= prod_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    first_r <= first_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/tbsd_back.sv
`default_nettype none

module tbsd_back
  import tbsd_pkg::*;
#(
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int GRID_ROWS = DEF_GRID_ROWS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cmd_t      head,
  input  qstat_t    q_stat,
  output logic      pop,
  output logic      init_done,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  localparam int         COL_W    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int         ROW_W    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic [7:0] LAST_COL = 8'(GRID_COLS - 1);
  localparam logic [7:0] LAST_ROW = 8'(GRID_ROWS - 1);

  typedef enum logic [7:0] {
    B_CLEAR    = 8'b0000_0001,
    B_IDLE     = 8'b0000_0010,
    B_PRD      = 8'b0000_0100,
    B_PWR      = 8'b0000_1000,
    B_SRD      = 8'b0001_0000,
    B_SLOAD    = 8'b0010_0000,
    B_SWALK    = 8'b0100_0000,
    B_DONE_OUT = 8'b1000_0000
  } bstate_t;

  bstate_t              st_r, st_nxt;
  logic [7:0]           clr_row_r, clr_row_nxt;
  logic [7:0]           py_r, py_nxt;
  logic [7:0]           pye_r, pye_nxt;
  logic [GRID_COLS-1:0] mask_r, mask_nxt;
  logic [GRID_COLS-1:0] row_r, row_nxt;
  logic [7:0]           srow_r, srow_nxt;
  logic [7:0]           scol_r, scol_nxt;
  logic                 scan_final_r, scan_final_nxt;
  logic                 pend_r, pend_nxt;
  logic                 fin_r, fin_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r;

  // Visited map, one row of cells per word
  logic [GRID_COLS-1:0] map_mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_q;
  logic                 wr_en, rd_en;
  logic [ROW_W-1:0]     wr_addr, rd_addr;
  logic [GRID_COLS-1:0] wr_data;

  logic                 out_free;
  logic                 emit;
  res_t                 emit_res;
  logic [GRID_COLS-1:0] rect_mask, col_bit;

  function automatic res_t fill_res(input logic [7:0] xs, input logic [7:0] ys,
                                    input logic [7:0] xe, input logic [7:0] ye,
                                    input logic four, input logic [5:0][7:0] pat);
    res_t r;
    r.kind       = KIND_FILL;
    r.x_start    = xs;
    r.y_start    = ys[6:0];
    r.x_end      = xe;
    r.y_end      = ye[6:0];
    r.four_rows  = four;
    r.blue_rows  = {pat[0], pat[3]};
    r.red_rows   = {pat[1], pat[4]};
    r.green_rows = {pat[2], pat[5]};
    return r;
  endfunction

  assign init_done = (st_r != B_CLEAR);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    for (int i = 0; i < GRID_COLS; i++) begin
      rect_mask[i] = (8'(i) >= head.xs) && (8'(i) <= head.xe);
      col_bit[i]   = (8'(i) == scol_r);
    end
  end

  always_comb begin
    st_nxt         = st_r;
    clr_row_nxt    = clr_row_r;
    py_nxt         = py_r;
    pye_nxt        = pye_r;
    mask_nxt       = mask_r;
    row_nxt        = row_r;
    srow_nxt       = srow_r;
    scol_nxt       = scol_r;
    scan_final_nxt = scan_final_r;
    pend_nxt       = pend_r;
    fin_nxt        = fin_r;
    pop            = 1'b0;
    emit           = 1'b0;
    emit_res       = '0;
    wr_en          = 1'b0;
    wr_addr        = py_r[ROW_W-1:0];
    wr_data        = rd_q | mask_r;
    rd_en          = 1'b0;
    rd_addr        = py_r[ROW_W-1:0];

    case (st_r)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row_r[ROW_W-1:0];
        wr_data = '0;
        if (clr_row_r == LAST_ROW) begin
          st_nxt = B_IDLE;
        end else begin
          clr_row_nxt = clr_row_r + 8'd1;
        end
      end
      B_IDLE: begin
        if (!q_stat.empty) begin
          case (head.op)
            CMD_DROP: begin
              if (out_free) begin
                emit          = 1'b1;
                emit_res.kind = KIND_DROP;
                pop           = 1'b1;
              end
            end
            CMD_PAINT: begin
              if (out_free) begin
                emit     = 1'b1;
                emit_res = fill_res(head.xs, head.ys, head.xe, head.ye, head.four, head.pat);
                pop      = 1'b1;
                py_nxt   = head.ys;
                pye_nxt  = head.ye;
                mask_nxt = rect_mask;
                st_nxt   = B_PRD;
              end
            end
            CMD_FINAL: begin
              pop            = 1'b1;
              srow_nxt       = 8'd0;
              scol_nxt       = 8'd0;
              scan_final_nxt = 1'b1;
              st_nxt         = B_SRD;
            end
            CMD_FBYTE: begin
              if (fin_r) begin
                pop = 1'b1;
              end else if (pend_r) begin
                if (out_free) begin
                  emit          = 1'b1;
                  emit_res.kind = KIND_DONE;
                  fin_nxt       = 1'b1;
                  pop           = 1'b1;
                end
              end else if (!head.tile_done) begin
                pop = 1'b1;
              end else if (out_free) begin
                // Mark the free cell found by the scan, then walk on from it
                emit           = 1'b1;
                emit_res       = fill_res(scol_r, srow_r, scol_r, srow_r, head.four, head.pat);
                pop            = 1'b1;
                wr_en          = 1'b1;
                wr_addr        = srow_r[ROW_W-1:0];
                wr_data        = row_r | col_bit;
                row_nxt        = row_r | col_bit;
                scan_final_nxt = 1'b0;
                st_nxt         = B_SWALK;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_PRD: begin
        rd_en  = 1'b1;
        st_nxt = B_PWR;
      end
      B_PWR: begin
        wr_en = 1'b1;
        if (py_r == pye_r) begin
          st_nxt = B_IDLE;
        end else begin
          py_nxt = py_r + 8'd1;
          st_nxt = B_PRD;
        end
      end
      B_SRD: begin
        rd_en   = 1'b1;
        rd_addr = srow_r[ROW_W-1:0];
        st_nxt  = B_SLOAD;
      end
      B_SLOAD: begin
        row_nxt = rd_q;
        st_nxt  = B_SWALK;
      end
      B_SWALK: begin
        if (!row_r[scol_r[COL_W-1:0]]) begin
          st_nxt = B_IDLE;
        end else if (scol_r == LAST_COL) begin
          scol_nxt = 8'd0;
          if (srow_r == LAST_ROW) begin
            if (scan_final_r) begin
              st_nxt = B_DONE_OUT;
            end else begin
              pend_nxt = 1'b1;
              st_nxt   = B_IDLE;
            end
          end else begin
            srow_nxt = srow_r + 8'd1;
            st_nxt   = B_SRD;
          end
        end else begin
          scol_nxt = scol_r + 8'd1;
        end
      end
      B_DONE_OUT: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.kind = KIND_DONE;
          fin_nxt       = 1'b1;
          st_nxt        = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_CLEAR;
      clr_row_r    <= 8'd0;
      scan_final_r <= 1'b0;
      pend_r       <= 1'b0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      clr_row_r    <= clr_row_nxt;
      scan_final_r <= scan_final_nxt;
      pend_r       <= pend_nxt;
      fin_r        <= fin_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    py_r   <= py_nxt;
    pye_r  <= pye_nxt;
    mask_r <= mask_nxt;
    row_r  <= row_nxt;
    srow_r <= srow_nxt;
    scol_r <= scol_nxt;
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= map_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tiled_bitmap_stream_decoder.sv
`default_nettype none

// Tiled bitmap stream decoder. Takes one stream byte per transfer on in_ch
// and hands fill, drop and completion results out on out_ch, at most one per
// byte. After reset the block sweeps the visited map, one row per cycle,
// while in_ch.ready stays low. A parser accepts a byte per cycle except
// after the two offset bytes of a rectangle record, where it pauses while
// the states PH_DIV1, PH_DIV2 and PH_DIV3 split the offset into row and
// column. Parsed commands wait in a four-entry queue for the map engine.
// The engine marks a rectangle one map row at a time, reading each row and
// writing it back, and after the closing end byte it looks for the next
// unvisited cell at one cell per cycle, loading each map row it walks
// through the states B_SRD and B_SLOAD. Both sides stall on their own; a
// full queue holds off input, a stalled out_ch holds the engine.

module tiled_bitmap_stream_decoder
  import tbsd_pkg::*;
#(
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int GRID_ROWS = DEF_GRID_ROWS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tbsd_in_if.sink    in_ch,
  tbsd_out_if.source out_ch
);

  logic   push, pop, init_done, out_valid;
  cmd_t   push_cmd, head;
  qstat_t q_stat;
  res_t   out_res;

  // Parse bytes into paint, drop, final and fill-byte commands
  tbsd_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .init_done (init_done),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Decouple parser from map engine
  tbsd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Walk the visited map and drive the result register
  tbsd_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_res.kind;
  assign out_ch.x_start    = out_res.x_start;
  assign out_ch.y_start    = out_res.y_start;
  assign out_ch.x_end      = out_res.x_end;
  assign out_ch.y_end      = out_res.y_end;
  assign out_ch.four_rows  = out_res.four_rows;
  assign out_ch.blue_rows  = out_res.blue_rows;
  assign out_ch.red_rows   = out_res.red_rows;
  assign out_ch.green_rows = out_res.green_rows;

  // No transfer in or out while the map sweep runs
  a_no_input_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_ch.ready)
    else $error("input ready during map sweep");

  a_no_output_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !out_ch.valid)
    else $error("result offered during map sweep");

  // A fill always covers a non-empty rectangle
  a_fill_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_FILL) |->
      (out_ch.x_start <= out_ch.x_end && out_ch.y_start <= out_ch.y_end))
    else $error("fill rectangle with start past end");

  // Drop and completion carry no coordinates
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != KIND_FILL) |->
      (out_ch.x_end == 8'd0 && out_ch.blue_rows == 16'd0 && out_ch.four_rows == 1'b0))
    else $error("non-fill result with payload");

endmodule

`default_nettype wire

FILE: test/tb_tiled_bitmap_stream_decoder.sv
module tb_tiled_bitmap_stream_decoder;
  import tbsd_pkg::*;

  localparam int COLS  = DEF_GRID_COLS;
  localparam int ROWS  = DEF_GRID_ROWS;
  localparam int CELLS = COLS * ROWS;

  // Quiet stretches include a full map scan after the closing end byte
  localparam int QUIET_LIMIT   = 100000;
  // Allow for the longest rectangle mark; let stray results show up
  localparam int DRAIN_CYCLES  = 400;
  localparam int RANDOM_BYTES  = 850;
  localparam int REPORT_LINES  = 50;

  // Rectangle head bits 7:6
  localparam logic [1:0] RUN_BOTH   = 2'b00;
  localparam logic [1:0] RUN_HORZ   = 2'b01;
  localparam logic [1:0] RUN_VERT   = 2'b10;
  localparam logic [1:0] RUN_VERT_H = 2'b11;

  typedef enum logic [3:0] {
    P_MODE, P_TILE, P_RHEAD, P_RLOW, P_VERT, P_HORZ, P_BOTHX, P_BOTHY,
    P_CELLX, P_CELLY, P_FILL, P_PENDING, P_DONE
  } stream_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  tbsd_in_if  in_if ();
  tbsd_out_if out_if ();

  tiled_bitmap_stream_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stream bytes waiting to be driven, and fill/drop/done commands the
  // decoder still owes us, oldest first
  logic [7:0] stream_bytes[$];
  res_t       results_due[$];

  int stream_total;
  int bytes_accepted  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  // Decoder shadow state
  stream_phase_t   phase;
  logic [7:0]      line_mode;
  logic [5:0][7:0] tile;
  int              tile_count;
  logic [13:0]     rec_offset;
  logic [7:0]      rec_head;
  logic [7:0]      held_byte;
  bit              visited [CELLS];
  int              scan_pos;

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  // Store one plane byte; the first three bytes also seed rows 2..3 so a
  // short tile repeats its rows. Return 1 once the tile is complete.
  function automatic bit take_tile_byte(logic [7:0] b);
    int need;
    int k;
    need = (line_mode > 1) ? TILE_LEN_LONG : TILE_LEN_SHORT;
    k = (tile_count >= need) ? 0 : tile_count;
    tile[k] = b;
    if (k < 3) tile[k + 3] = b;
    k++;
    tile_count = (k >= need) ? 0 : k;
    return k >= need;
  endfunction

  function automatic res_t fill_cmd(int xs, int ys, int xe, int ye);
    res_t r;
    r.kind       = KIND_FILL;
    r.x_start    = xs[7:0];
    r.y_start    = ys[6:0];
    r.x_end      = xe[7:0];
    r.y_end      = ye[6:0];
    r.four_rows  = (line_mode != 0);
    r.blue_rows  = {tile[0], tile[3]};
    r.red_rows   = {tile[1], tile[4]};
    r.green_rows = {tile[2], tile[5]};
    return r;
  endfunction

  function automatic res_t status_cmd(res_kind_t k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // Empty rectangles vanish; anything touching off-grid drops as a whole
  function automatic void paint_rect(int xs, int ys, int xe, int ye);
    int x;
    int y;
    if (xe < xs || ye < ys) return;
    if (xs >= COLS || xe >= COLS || ys >= ROWS || ye >= ROWS) begin
      results_due.push_back(status_cmd(KIND_DROP));
      return;
    end
    for (y = ys; y <= ye; y++)
      for (x = xs; x <= xe; x++) visited[y * COLS + x] = 1'b1;
    results_due.push_back(fill_cmd(xs, ys, xe, ye));
  endfunction

  function automatic int next_unvisited(int from);
    while (from < CELLS && visited[from]) from++;
    return from;
  endfunction

  // Advance the shadow parser by one accepted byte and queue what it owes
  function automatic void decode_byte(logic [7:0] b);
    int xs;
    int ys;
    xs = int'(rec_offset) % COLS;
    ys = int'(rec_offset) / COLS;
    case (phase)
      P_MODE: begin
        if (b == BYTE_END) begin
          // End of groups: switch to the raster fill of what is left
          if (line_mode != 0) line_mode = 8'd2;
          tile_count = 0;
          scan_pos = next_unvisited(0);
          if (scan_pos >= CELLS) begin
            phase = P_DONE;
            results_due.push_back(status_cmd(KIND_DONE));
          end else begin
            phase = P_FILL;
          end
        end else begin
          line_mode = b;
          tile_count = 0;
          phase = P_TILE;
        end
      end
      P_TILE: if (take_tile_byte(b)) phase = P_RHEAD;
      P_RHEAD: begin
        if (b == BYTE_END) begin
          phase = P_CELLX;
        end else begin
          rec_head = b;
          phase = P_RLOW;
        end
      end
      P_RLOW: begin
        rec_offset = {rec_head[5:0], b};
        if (rec_head[HEAD_VERT_BIT]) phase = P_VERT;
        else if (rec_head[HEAD_HORZ_BIT]) phase = P_HORZ;
        else phase = P_BOTHX;
      end
      P_VERT: begin
        phase = P_RHEAD;
        paint_rect(xs, ys, xs, b);
      end
      P_HORZ: begin
        phase = P_RHEAD;
        paint_rect(xs, ys, b, ys);
      end
      P_BOTHX: begin
        held_byte = b;
        phase = P_BOTHY;
      end
      P_BOTHY: begin
        phase = P_RHEAD;
        paint_rect(xs, ys, held_byte, b);
      end
      P_CELLX: begin
        if (b == BYTE_END) begin
          phase = P_MODE;
        end else begin
          held_byte = b;
          phase = P_CELLY;
        end
      end
      P_CELLY: begin
        phase = P_CELLX;
        paint_rect(held_byte, b, held_byte, b);
      end
      P_FILL: begin
        if (take_tile_byte(b)) begin
          if (scan_pos >= CELLS) begin
            phase = P_PENDING;
          end else begin
            visited[scan_pos] = 1'b1;
            xs = scan_pos % COLS;
            ys = scan_pos / COLS;
            scan_pos = next_unvisited(scan_pos + 1);
            if (scan_pos >= CELLS) phase = P_PENDING;
            results_due.push_back(fill_cmd(xs, ys, xs, ys));
          end
        end
      end
      // Whatever byte comes after the last fill tile closes the image
      P_PENDING: begin
        phase = P_DONE;
        results_due.push_back(status_cmd(KIND_DONE));
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------

  function automatic logic [7:0] pick_mode();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'd0;
      4, 5, 6:    return 8'd1;
      7:          return 8'd2;
      default:    return 8'($urandom_range(3, 254));
    endcase
  endfunction

  task automatic push_tile(logic [7:0] mode);
    int need;
    need = (mode > 1) ? TILE_LEN_LONG : TILE_LEN_SHORT;
    repeat (need) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Head, offset low byte, then the end bytes that the run type calls for
  task automatic push_rect(logic [1:0] run, int off, int xe, int ye);
    stream_bytes.push_back({run, off[13:8]});
    stream_bytes.push_back(off[7:0]);
    if (run[1]) begin
      stream_bytes.push_back(ye[7:0]);
    end else if (run[0]) begin
      stream_bytes.push_back(xe[7:0]);
    end else begin
      stream_bytes.push_back(xe[7:0]);
      stream_bytes.push_back(ye[7:0]);
    end
  endtask

  // Sender and receiver swap idle rates after the first third of the stream,
  // then both run flat out for the last third
  function automatic int idle_pct(bit receiver);
    if (bytes_accepted < stream_total / 3) return receiver ? 56 : 15;
    if (bytes_accepted < 2 * stream_total / 3) return receiver ? 15 : 56;
    return 0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("mismatch at result %0d: %s", results_checked, msg);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: hold a byte until its transfer, then fetch the next one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= stream_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: compare each transfer against the oldest command owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("kind %0d with nothing pending", out_if.kind));
        end else begin
          want = results_due.pop_front();
          if (out_if.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_if.kind, want.kind));
          if (out_if.x_start !== want.x_start)
            report_mismatch($sformatf("x_start %0d, expected %0d",
                                      out_if.x_start, want.x_start));
          if (out_if.y_start !== want.y_start)
            report_mismatch($sformatf("y_start %0d, expected %0d",
                                      out_if.y_start, want.y_start));
          if (out_if.x_end !== want.x_end)
            report_mismatch($sformatf("x_end %0d, expected %0d", out_if.x_end, want.x_end));
          if (out_if.y_end !== want.y_end)
            report_mismatch($sformatf("y_end %0d, expected %0d", out_if.y_end, want.y_end));
          if (out_if.four_rows !== want.four_rows)
            report_mismatch($sformatf("four_rows %0b, expected %0b",
                                      out_if.four_rows, want.four_rows));
          if (out_if.blue_rows !== want.blue_rows)
            report_mismatch($sformatf("blue_rows %h, expected %h",
                                      out_if.blue_rows, want.blue_rows));
          if (out_if.red_rows !== want.red_rows)
            report_mismatch($sformatf("red_rows %h, expected %h",
                                      out_if.red_rows, want.red_rows));
          if (out_if.green_rows !== want.green_rows)
            report_mismatch($sformatf("green_rows %h, expected %h",
                                      out_if.green_rows, want.green_rows));
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL tiled_bitmap_stream_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    logic [7:0] mode;
    logic [1:0] run;
    int xs;
    int ys;
    int xe;
    int ye;
    int span;
    int off;
    int col;
    int row;
    int holes;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;

    phase      = P_MODE;
    line_mode  = '0;
    tile       = '0;
    tile_count = 0;
    rec_offset = '0;
    rec_head   = '0;
    held_byte  = '0;
    scan_pos   = 0;

    // Leave the last `holes` cells of the bottom row unvisited so the
    // closing raster fill stays short. Random records never touch row 99.
    holes = $urandom_range(1, 40);

    // Directed group: short tile with extreme plane bytes, one record of
    // each run type, an empty rectangle and off-grid drops
    stream_bytes = {8'h00, 8'h00, BYTE_END, 8'h5A};
    push_rect(RUN_VERT, 0, 0, ROWS - 1);               // full-height column 0
    push_rect(RUN_HORZ, 10 * COLS + 3, COLS - 1, 0);   // row 10 out to the right edge
    push_rect(RUN_BOTH, COLS + 1, 2, 0);               // end row above start: empty
    push_rect(RUN_BOTH, 16127, 200, 120);              // starts below the grid: drop
    stream_bytes = {stream_bytes, BYTE_END, 8'd160, 8'd5, BYTE_END};
    // Odd mode byte: six-byte tile, four rows; no rectangles, one far cell
    stream_bytes = {stream_bytes, 8'hFE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
                    BYTE_END, 8'd254, 8'd255, BYTE_END};

    // Random groups: mostly well-formed records in the grid, the rest
    // off-grid starts, random ends (empty or dropped) and far cells
    while (stream_bytes.size() < RANDOM_BYTES) begin
      mode = pick_mode();
      stream_bytes.push_back(mode);
      push_tile(mode);
      repeat ($urandom_range(0, 4)) begin
        run = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
          xs = $urandom_range(0, COLS - 1);
          ys = $urandom_range(0, ROWS - 2);
          // Keep most rectangles small; marking cost grows with rows
          span = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 7);
          xe = (xs + span > COLS - 1) ? COLS - 1 : xs + span;
          ye = (ys + span > ROWS - 2) ? ROWS - 2 : ys + span;
          push_rect(run, ys * COLS + xs, xe, ye);
        end else if ($urandom_range(0, 1) != 0) begin
          off = $urandom_range(CELLS, 16383);
          // Avoid a head that reads as the list end
          if (run == RUN_VERT_H && off[13:8] == 6'h3F) run = RUN_VERT;
          push_rect(run, off, $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          xs = $urandom_range(0, COLS - 1);
          ys = $urandom_range(0, ROWS - 2);
          ye = $urandom_range(0, 255);
          if (ye == ROWS - 1) ye = ROWS;
          push_rect(run, ys * COLS + xs, $urandom_range(0, 255), ye);
        end
      end
      stream_bytes.push_back(BYTE_END);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 3) != 0) begin
          col = $urandom_range(0, COLS - 1);
          row = $urandom_range(0, ROWS - 2);
        end else begin
          col = $urandom_range(0, 254);
          row = $urandom_range(0, 255);
          if (row == ROWS - 1) row = ROWS;
        end
        stream_bytes.push_back(col[7:0]);
        stream_bytes.push_back(row[7:0]);
      end
      stream_bytes.push_back(BYTE_END);
    end

    // Closing group: cover everything but the tail of the bottom row, end
    // the groups, supply one tile per hole, then the byte that completes
    // the image and a few that must be ignored
    mode = pick_mode();
    stream_bytes.push_back(mode);
    push_tile(mode);
    push_rect(RUN_BOTH, 0, COLS - 1, ROWS - 2);
    push_rect(RUN_HORZ, (ROWS - 1) * COLS, COLS - 1 - holes, 0);
    stream_bytes = {stream_bytes, BYTE_END, BYTE_END, BYTE_END};
    repeat (holes) push_tile((mode != 0) ? 8'd2 : 8'd0);
    repeat (4) stream_bytes.push_back(8'($urandom_range(0, 255)));
    stream_total = stream_bytes.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to transfer, every owed result to arrive, then
    // give stray results time to show up
    while (bytes_accepted < stream_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS tiled_bitmap_stream_decoder");
    end else begin
      $display("FAIL tiled_bitmap_stream_decoder");
    end
    $finish;
  end

endmodule
